@@ hdl/skoc_pkg.sv @@
// Package for the sorted key order checker.
// Holds the comparison and status codes and the default maximum key length.
// No dependencies.
package skoc_pkg;

  localparam int unsigned MAX_KEY_BYTES_DEF = 256;

  typedef enum logic [1:0] {
    ORD_EQUAL   = 2'd0,
    ORD_LESS    = 2'd1,
    ORD_GREATER = 2'd2
  } ord_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ORDER  = 2'd1,
    ST_LONG   = 2'd2,
    ST_FAILED = 2'd3
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [15:0] index;
  } result_t;

endpackage

@@ hdl/sorted_key_order_checker.sv @@
// Sorted key order checker: one byte per transaction, one verdict per element end.
// Two register stages (s1, output) lie between the closing byte and its verdict;
// throughput 1 byte per cycle unless a verdict is held back by the output.
// Reset: rst_ni clears pipeline valids, list history, failure flag and element count;
// the byte store is not cleared and needs no clearing pass.
// Depends on skoc_pkg.
module sorted_key_order_checker
  import skoc_pkg::*;
#(
  parameter int unsigned MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] byte_value
  input  logic [1:0]  s_axis_tuser_i,   // [0] has_byte, [1] start_list
  input  logic        s_axis_tlast_i,   // end_of_element
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // [1:0] status, [17:2] element_index, [23:18] zero
);

  localparam int unsigned AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int unsigned LW = $clog2(MAX_KEY_BYTES + 2);
  localparam logic [LW-1:0] MaxLen  = LW'(MAX_KEY_BYTES);
  localparam logic [LW-1:0] LongLen = LW'(MAX_KEY_BYTES + 1);

  typedef struct packed {
    logic          start;
    logic          take;
    logic          eoe;
    logic [7:0]    data;
    logic [LW-1:0] pos;
    logic [LW-1:0] len;
  } stage_t;

  logic [7:0] mem_q [MAX_KEY_BYTES];
  logic [7:0] rd_q;

  logic          s_acc;
  logic [LW-1:0] cur_len_q, cur_len_d;
  logic [LW-1:0] pos;
  logic          take;
  logic [LW-1:0] len_after;
  logic [AW-1:0] rd_addr;

  stage_t s1_q, s1_d;
  logic   s1_valid_q;
  logic   s1_adv;
  logic   out_free;
  logic   we;

  logic [LW-1:0] prev_len_q, prev_len_d;
  logic          have_prev_q, have_prev_d;
  logic          failed_q, failed_d;
  ord_e          order_q, order_d;
  logic [15:0]   count_q, count_d;

  logic          hp, fl;
  ord_e          po;
  logic [LW-1:0] plen;
  logic [15:0]   cnt;

  result_t res_d, out_q;
  logic    out_valid_q;

  assign s_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign s1_adv   = s1_valid_q && (!s1_q.eoe || out_free);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign we       = s1_adv && s1_q.take;

  always_comb begin
    pos       = s_axis_tuser_i[1] ? '0 : cur_len_q;
    take      = s_axis_tuser_i[0] && (pos < MaxLen);
    len_after = pos;
    if (take) begin
      len_after = pos + LW'(1);
    end else if (s_axis_tuser_i[0]) begin
      len_after = LongLen;
    end
    rd_addr   = take ? pos[AW-1:0] : '0;
    cur_len_d = s_axis_tlast_i ? '0 : len_after;
    s1_d.start = s_axis_tuser_i[1];
    s1_d.take  = take;
    s1_d.eoe   = s_axis_tlast_i;
    s1_d.data  = s_axis_tdata_i;
    s1_d.pos   = pos;
    s1_d.len   = len_after;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[s1_q.pos[AW-1:0]] <= s1_q.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      if (we && (s1_q.pos[AW-1:0] == rd_addr)) begin
        rd_q <= s1_q.data;
      end else begin
        rd_q <= mem_q[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_len_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (s_acc) begin
        cur_len_q <= cur_len_d;
      end
      if (s_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_q <= s1_d;
    end
  end

  always_comb begin
    hp   = s1_q.start ? 1'b0 : have_prev_q;
    fl   = s1_q.start ? 1'b0 : failed_q;
    po   = s1_q.start ? ORD_EQUAL : order_q;
    plen = s1_q.start ? '0 : prev_len_q;
    cnt  = s1_q.start ? '0 : count_q;

    order_d = po;
    if (s1_q.take && hp && (po == ORD_EQUAL)) begin
      if (s1_q.pos < plen) begin
        if (rd_q < s1_q.data) begin
          order_d = ORD_GREATER;
        end else if (rd_q > s1_q.data) begin
          order_d = ORD_LESS;
        end
      end else begin
        order_d = ORD_GREATER;
      end
    end

    have_prev_d = hp;
    failed_d    = fl;
    prev_len_d  = plen;
    count_d     = cnt;
    res_d.index = cnt;
    res_d.status = ST_OK;
    if (s1_q.eoe) begin
      priority if (fl) begin
        res_d.status = ST_FAILED;
      end else if (s1_q.len > MaxLen) begin
        res_d.status = ST_LONG;
        failed_d     = 1'b1;
      end else if (hp && (order_d != ORD_GREATER)) begin
        res_d.status = ST_ORDER;
        failed_d     = 1'b1;
      end else begin
        prev_len_d  = s1_q.len;
        have_prev_d = 1'b1;
      end
      if (cnt != 16'hFFFF) begin
        count_d = cnt + 16'd1;
      end
      order_d = ORD_EQUAL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_len_q  <= '0;
      have_prev_q <= 1'b0;
      failed_q    <= 1'b0;
      order_q     <= ORD_EQUAL;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        prev_len_q  <= prev_len_d;
        have_prev_q <= have_prev_d;
        failed_q    <= failed_d;
        order_q     <= order_d;
        count_q     <= count_d;
      end
      if (s1_adv && s1_q.eoe) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.eoe) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_q.index, out_q.status};

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> s1_valid_q)
    else $error("input stalled with an empty stage");

  a_sticky_failure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_q.eoe && !s1_q.start && failed_q) |=> (out_q.status == ST_FAILED))
    else $error("failure not reported as sticky");

  a_prev_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prev_len_q <= MaxLen)
    else $error("stored key length exceeds store depth");
`endif

endmodule
